// ===== hw/rtl/gte_pkg.sv =====
`default_nettype none
package gte_pkg;

    localparam int LAT_W = 32;
    localparam int LON_W = 33;
    localparam int HGT_W = 28;
    localparam int SMA_W = 34;
    localparam int ECC_W = 31;
    localparam int OUT_W = 34;
    localparam int CFG_IDX_W = 2;
    localparam int TRIG_W = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_MAJOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECC_SQ     = 2'd1;

    localparam logic [SMA_W-1:0] SMA_RESET = 34'd6378137000;
    localparam logic [ECC_W-1:0] ECC_RESET = 31'd28752143;

    localparam logic signed [TRIG_W-1:0] GAIN_INV = 33'sd652032874;
    localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [TRIG_W-1:0] clat;
        logic signed [TRIG_W-1:0] slat;
        logic signed [TRIG_W-1:0] clon;
        logic signed [TRIG_W-1:0] slon;
        logic signed [HGT_W-1:0]  h;
    } side_t;

    // floor(atan(2^-i) * 2^30)
    function automatic logic signed [TRIG_W-1:0] atan_q30(input int i);
        logic signed [TRIG_W-1:0] v;
        case (i)
            0:  v = 33'sh03243F6A8;
            1:  v = 33'sh01DAC6705;
            2:  v = 33'sh00FADBAFC;
            3:  v = 33'sh007F56EA6;
            4:  v = 33'sh003FEAB76;
            5:  v = 33'sh001FFD55B;
            6:  v = 33'sh000FFFAAA;
            7:  v = 33'sh0007FFF55;
            8:  v = 33'sh0003FFFEA;
            9:  v = 33'sh0001FFFFD;
            10: v = 33'sh0000FFFFF;
            11: v = 33'sh00007FFFF;
            12: v = 33'sh00003FFFF;
            13: v = 33'sh00001FFFF;
            14: v = 33'sh00000FFFF;
            15: v = 33'sh000007FFF;
            16: v = 33'sh000003FFF;
            17: v = 33'sh000001FFF;
            18: v = 33'sh000000FFF;
            19: v = 33'sh0000007FF;
            20: v = 33'sh0000003FF;
            21: v = 33'sh0000001FF;
            22: v = 33'sh0000000FF;
            23: v = 33'sh00000007F;
            24: v = 33'sh00000003F;
            25: v = 33'sh00000001F;
            26: v = 33'sh00000000F;
            27: v = 33'sh000000007;
            28: v = 33'sh000000003;
            29: v = 33'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/geodetic_to_ecef_top.sv =====
`default_nettype none
// channel   | handshake              | payload
// request   | start / busy           | latitude, longitude, height
// result    | result_valid (strobe)  | ecef_x, ecef_y, ecef_z
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle; busy is never raised. The path runs through the
// CORDIC stages, the 31 stage square root and the 35 stage divider. rst_n clears
// the valid line and loads the default config; datapath registers are not reset.
// No stalls: each result shows for one cycle only.
module geodetic_to_ecef_top #(
    parameter int ANGLE_FRAC_BITS = 24,
    parameter int TRIG_ITERATIONS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [gte_pkg::LAT_W-1:0]    latitude,
    input  wire logic signed [gte_pkg::LON_W-1:0]    longitude,
    input  wire logic signed [gte_pkg::HGT_W-1:0]    height,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [gte_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [gte_pkg::SMA_W-1:0]           cfg_data,
    output logic                                     result_valid,
    output logic signed [gte_pkg::OUT_W-1:0]         ecef_x,
    output logic signed [gte_pkg::OUT_W-1:0]         ecef_y,
    output logic signed [gte_pkg::OUT_W-1:0]         ecef_z
);

    localparam int F   = ANGLE_FRAC_BITS;
    localparam int IT  = TRIG_ITERATIONS;
    localparam int UW  = 41 - F;
    localparam int MS  = UW + 1;
    localparam int MW  = MS - 6;
    localparam int KW  = UW - 6;
    localparam int DW  = F + 7;
    localparam int ZPW = DW + 27;
    localparam logic [MW-1:0] RECIP   = MW'((64'd1 << MS) / 64'd90);
    localparam logic [UW-1:0] ANG_OFF = UW'(360 << (32 - F));

    localparam int AW = 41;
    localparam int HW = (AW - 1) / 2;
    localparam int PW = HW + 33;
    localparam int RW = 44;

    localparam int P_D    = 4;
    localparam int SQ_N   = 31;
    localparam int P_ROOT = P_D + SQ_N;
    localparam int DV_N   = 35;
    localparam int P_QUO  = P_ROOT + 1 + DV_N;
    localparam int P_NH   = P_QUO + 1;
    localparam int P_C1   = P_NH + 3;
    localparam int P_ZH   = P_C1 + 1;
    localparam int P_SAT  = P_ZH + 4;
    localparam int PB     = 4 + IT;
    localparam int NST    = PB + P_SAT + 1;

    localparam logic signed [RW-1:0] SAT_HI = 44'sd8589934591;
    localparam logic signed [RW-1:0] SAT_LO = -44'sd8589934592;

    logic [gte_pkg::SMA_W-1:0] sma_reg;
    logic [gte_pkg::ECC_W-1:0] ecc_reg;
    logic [NST-1:0]            vld_reg;

    assign busy         = 1'b0;
    assign cfg_ready    = 1'b1;
    assign result_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sma_reg <= gte_pkg::SMA_RESET;
            ecc_reg <= gte_pkg::ECC_RESET;
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NST-2:0], start & ~busy};
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gte_pkg::CFG_SEMI_MAJOR: sma_reg <= cfg_data;
                    gte_pkg::CFG_ECC_SQ:     ecc_reg <= cfg_data[gte_pkg::ECC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // angle reduction: quadrant and remainder below 90 degrees
    logic signed [gte_pkg::HGT_W-1:0] h_reg [PB];
    logic [UW-1:0] uu0_reg [2];
    logic [UW-1:0] uu1_reg [2];
    logic [F-1:0]  lo0_reg [2];
    logic [F-1:0]  lo1_reg [2];
    logic [KW-1:0] kest_reg [2];
    logic [DW-1:0] remd_reg [2];
    logic [1:0]    quad_reg [2];

    logic signed [gte_pkg::TRIG_W-1:0] cx_reg [IT+1][2];
    logic signed [gte_pkg::TRIG_W-1:0] cy_reg [IT+1][2];
    logic signed [gte_pkg::TRIG_W-1:0] cz_reg [IT+1][2];
    logic [1:0]                        cq_reg [IT+1][2];

    logic signed [32:0]   ang [2];
    logic [UW+MW-1:0]     kprod [2];
    logic [UW-1:0]        kdiff [2];
    logic [7:0]           r8 [2];
    logic [6:0]           r7 [2];
    logic [KW-1:0]        kfix [2];
    logic [ZPW-1:0]       zprod [2];

    always_comb
    begin
        ang[0] = 33'(latitude);
        ang[1] = longitude;
        for (int a = 0; a < 2; a++)
        begin
            kprod[a] = (UW+MW)'(uu0_reg[a]) * (UW+MW)'(RECIP);
            kdiff[a] = uu1_reg[a] - UW'(UW'(kest_reg[a]) * UW'(90));
            r8[a]    = kdiff[a][7:0];
            if (r8[a] >= 8'd90)
            begin
                r7[a]   = 7'(r8[a] - 8'd90);
                kfix[a] = kest_reg[a] + KW'(1);
            end
            else
            begin
                r7[a]   = r8[a][6:0];
                kfix[a] = kest_reg[a];
            end
            zprod[a] = ZPW'(remd_reg[a]) * ZPW'(gte_pkg::DEG_TO_RAD_Q32)
                     + (ZPW'(1) << (F + 1));
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg[0] <= height;
        for (int s = 1; s < PB; s++)
            h_reg[s] <= h_reg[s-1];
        for (int a = 0; a < 2; a++)
        begin
            uu0_reg[a]   <= UW'(ang[a] >>> F) + ANG_OFF;
            lo0_reg[a]   <= ang[a][F-1:0];
            kest_reg[a]  <= KW'(kprod[a] >> MS);
            uu1_reg[a]   <= uu0_reg[a];
            lo1_reg[a]   <= lo0_reg[a];
            remd_reg[a]  <= {r7[a], lo1_reg[a]};
            quad_reg[a]  <= kfix[a][1:0];
            cx_reg[0][a] <= gte_pkg::GAIN_INV;
            cy_reg[0][a] <= '0;
            cz_reg[0][a] <= $signed(33'(zprod[a] >> (F + 2)));
            cq_reg[0][a] <= quad_reg[a];
        end
    end

    // CORDIC, one rotation per stage, latitude and longitude side by side
    for (genvar j = 1; j <= IT; j++)
    begin : g_cordic
        localparam int I = j - 1;
        always_ff @(posedge clk)
        begin
            for (int a = 0; a < 2; a++)
            begin
                if (!cz_reg[j-1][a][gte_pkg::TRIG_W-1])
                begin
                    cx_reg[j][a] <= cx_reg[j-1][a] - (cy_reg[j-1][a] >>> I);
                    cy_reg[j][a] <= cy_reg[j-1][a] + (cx_reg[j-1][a] >>> I);
                    cz_reg[j][a] <= cz_reg[j-1][a] - gte_pkg::atan_q30(I);
                end
                else
                begin
                    cx_reg[j][a] <= cx_reg[j-1][a] + (cy_reg[j-1][a] >>> I);
                    cy_reg[j][a] <= cy_reg[j-1][a] - (cx_reg[j-1][a] >>> I);
                    cz_reg[j][a] <= cz_reg[j-1][a] + gte_pkg::atan_q30(I);
                end
                cq_reg[j][a] <= cq_reg[j-1][a];
            end
        end
    end

    // quadrant fold, sin^2 lat, denominator
    gte_pkg::side_t side_reg [P_ZH+1];
    gte_pkg::side_t side_next;
    logic signed [gte_pkg::TRIG_W-1:0] cosv [2];
    logic signed [gte_pkg::TRIG_W-1:0] sinv [2];
    logic signed [gte_pkg::TRIG_W-1:0] slat_abs;
    logic [30:0] mag_reg;
    logic [61:0] sqp_reg;
    logic [32:0] s2_reg;
    logic [63:0] ep_reg;
    logic [33:0] s2_round;

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            case (cq_reg[IT][a])
                gte_pkg::QUAD_0:
                begin
                    cosv[a] = cx_reg[IT][a];
                    sinv[a] = cy_reg[IT][a];
                end
                gte_pkg::QUAD_1:
                begin
                    cosv[a] = -cy_reg[IT][a];
                    sinv[a] = cx_reg[IT][a];
                end
                gte_pkg::QUAD_2:
                begin
                    cosv[a] = -cx_reg[IT][a];
                    sinv[a] = -cy_reg[IT][a];
                end
                default:
                begin
                    cosv[a] = cy_reg[IT][a];
                    sinv[a] = -cx_reg[IT][a];
                end
            endcase
        end
        side_next.clat = cosv[0];
        side_next.slat = sinv[0];
        side_next.clon = cosv[1];
        side_next.slon = sinv[1];
        side_next.h    = h_reg[PB-1];
        slat_abs       = sinv[0][gte_pkg::TRIG_W-1] ? -sinv[0] : sinv[0];
        s2_round       = 34'((sqp_reg + (62'd1 << 27)) >> 28);
    end

    logic [61:0] sr_rem_reg  [SQ_N+1];
    logic [30:0] sr_root_reg [SQ_N+1];

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int p = 1; p <= P_ZH; p++)
            side_reg[p] <= side_reg[p-1];
        mag_reg <= slat_abs[30:0];
        sqp_reg <= 62'(mag_reg) * 62'(mag_reg);
        s2_reg  <= (s2_round > 34'h1_0000_0000) ? 33'h1_0000_0000 : s2_round[32:0];
        ep_reg  <= 64'(ecc_reg) * 64'(s2_reg);
        sr_rem_reg[0]  <= (62'd1 << 60) - 62'(ep_reg >> 4);
        sr_root_reg[0] <= '0;
    end

    // square root, one result bit per stage
    for (genvar m = 1; m <= SQ_N; m++)
    begin : g_sqrt
        localparam int K = SQ_N - m;
        logic [61:0] trial;
        assign trial = (62'(sr_root_reg[m-1]) << (K + 1)) + (62'd1 << (2 * K));
        always_ff @(posedge clk)
        begin
            if (sr_rem_reg[m-1] >= trial)
            begin
                sr_rem_reg[m]  <= sr_rem_reg[m-1] - trial;
                sr_root_reg[m] <= sr_root_reg[m-1] | (31'd1 << K);
            end
            else
            begin
                sr_rem_reg[m]  <= sr_rem_reg[m-1];
                sr_root_reg[m] <= sr_root_reg[m-1];
            end
        end
    end

    // N = (a * 2^30 + sq/2) / sq, restoring divider
    logic [30:0] dv_rem_reg [DV_N+1];
    logic [34:0] dv_lo_reg  [DV_N+1];
    logic [34:0] dv_quo_reg [DV_N+1];
    logic [30:0] dv_sq_reg  [DV_N+1];
    logic [64:0] dvd;

    assign dvd = (65'(sma_reg) << 30) + 65'(sr_root_reg[SQ_N] >> 1);

    always_ff @(posedge clk)
    begin
        dv_rem_reg[0] <= 31'(dvd[64:35]);
        dv_lo_reg[0]  <= dvd[34:0];
        dv_quo_reg[0] <= '0;
        dv_sq_reg[0]  <= sr_root_reg[SQ_N];
    end

    for (genvar m = 1; m <= DV_N; m++)
    begin : g_div
        localparam int B = DV_N - m;
        logic [31:0] rs;
        assign rs = {dv_rem_reg[m-1], dv_lo_reg[m-1][B]};
        always_ff @(posedge clk)
        begin
            dv_lo_reg[m] <= dv_lo_reg[m-1];
            dv_sq_reg[m] <= dv_sq_reg[m-1];
            if (rs >= {1'b0, dv_sq_reg[m-1]})
            begin
                dv_rem_reg[m] <= 31'(rs - {1'b0, dv_sq_reg[m-1]});
                dv_quo_reg[m] <= dv_quo_reg[m-1] | (35'd1 << B);
            end
            else
            begin
                dv_rem_reg[m] <= rs[30:0];
                dv_quo_reg[m] <= dv_quo_reg[m-1];
            end
        end
    end

    // rounded products: lanes 0,1 give (N+h)cos lat and N(1-e2); 2..4 give X, Y, Z
    logic signed [AW-1:0] n_reg;
    logic signed [AW-1:0] nh_reg;
    logic signed [AW-1:0] t_reg;
    logic signed [AW-1:0] nbh_reg;
    logic signed [AW-1:0] la [5];
    logic signed [33:0]   lb [5];
    logic [AW-2:0]        ua_reg [5];
    logic [32:0]          ub_reg [5];
    logic                 nega_reg [5];
    logic                 negb_reg [5];
    logic [PW-1:0]        plo_reg [5];
    logic [PW-1:0]        phi_reg [5];
    logic signed [RW-1:0] mr_reg [5];

    always_comb
    begin
        la[0] = nh_reg;
        la[1] = n_reg;
        la[2] = t_reg;
        la[3] = t_reg;
        la[4] = nbh_reg;
        lb[0] = 34'(side_reg[P_NH].clat);
        lb[1] = $signed((34'd1 << 32) - 34'(ecc_reg));
        lb[2] = 34'(side_reg[P_ZH].clon);
        lb[3] = 34'(side_reg[P_ZH].slon);
        lb[4] = 34'(side_reg[P_ZH].slat);
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= AW'($signed({1'b0, dv_quo_reg[DV_N]}));
        nh_reg  <= AW'($signed({1'b0, dv_quo_reg[DV_N]})) + AW'(side_reg[P_QUO].h);
        t_reg   <= AW'(mr_reg[0]);
        nbh_reg <= AW'(mr_reg[1] + RW'(side_reg[P_C1].h));
    end

    for (genvar l = 0; l < 5; l++)
    begin : g_lane
        localparam int S = (l == 1) ? 32 : 30;
        logic [PW+HW-1:0] prod;
        logic [PW+HW-S-1:0] rnd;
        assign prod = (PW+HW)'(phi_reg[l]) * (PW+HW)'(2 ** HW) + (PW+HW)'(plo_reg[l]);
        assign rnd  = (PW+HW-S)'((prod + ((PW+HW)'(1) << (S - 1))) >> S);
        always_ff @(posedge clk)
        begin
            ua_reg[l]   <= la[l][AW-1] ? (AW-1)'(-la[l]) : (AW-1)'(la[l]);
            ub_reg[l]   <= lb[l][33] ? 33'(-lb[l]) : 33'(lb[l]);
            nega_reg[l] <= la[l][AW-1] ^ lb[l][33];
            plo_reg[l]  <= PW'(ua_reg[l][HW-1:0]) * PW'(ub_reg[l]);
            phi_reg[l]  <= PW'(ua_reg[l][2*HW-1:HW]) * PW'(ub_reg[l]);
            negb_reg[l] <= nega_reg[l];
            mr_reg[l]   <= negb_reg[l] ? -$signed(RW'(rnd)) : $signed(RW'(rnd));
        end
    end

    logic signed [RW-1:0] sat_in  [3];
    logic signed [gte_pkg::OUT_W-1:0] sat_out [3];
    logic signed [gte_pkg::OUT_W-1:0] ecef_x_reg;
    logic signed [gte_pkg::OUT_W-1:0] ecef_y_reg;
    logic signed [gte_pkg::OUT_W-1:0] ecef_z_reg;

    always_comb
    begin
        for (int o = 0; o < 3; o++)
        begin
            sat_in[o] = mr_reg[o + 2];
            if (sat_in[o] > SAT_HI)
                sat_out[o] = gte_pkg::OUT_W'(SAT_HI);
            else if (sat_in[o] < SAT_LO)
                sat_out[o] = gte_pkg::OUT_W'(SAT_LO);
            else
                sat_out[o] = gte_pkg::OUT_W'(sat_in[o]);
        end
    end

    always_ff @(posedge clk)
    begin
        ecef_x_reg <= sat_out[0];
        ecef_y_reg <= sat_out[1];
        ecef_z_reg <= sat_out[2];
    end

    assign ecef_x = ecef_x_reg;
    assign ecef_y = ecef_y_reg;
    assign ecef_z = ecef_z_reg;

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##NST result_valid)
        else $error("result strobe missing after request");

    a_quad_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> (remd_reg[0][DW-1:F] < 7'd90 && remd_reg[1][DW-1:F] < 7'd90))
        else $error("angle remainder not below a quarter turn");

    a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[PB+P_ROOT] |-> sr_root_reg[SQ_N][30:29] != 2'b00)
        else $error("square root below its lower bound");
`endif

endmodule
`default_nettype wire
